>>> sv/range_triangle_gate_macros.svh
// assertion macros for the range triangle gate
`ifndef RANGE_TRIANGLE_GATE_MACROS_SVH
`define RANGE_TRIANGLE_GATE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RTG_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/rtg_pkg.sv
// ----------------------------------------------------------------------------
// rtg_pkg
// shared types and constants of the range triangle gate
// ----------------------------------------------------------------------------
package rtg_pkg;

  // range and coordinate width, signed millimetres
  localparam int unsigned CoordW = 24;
  localparam int unsigned MaxRangeW = 23;
  // position within a set and slot/count fields of a queue entry
  localparam int unsigned PosW = 5;
  localparam int unsigned NumW = 6;
  localparam int unsigned MaskW = 32;
  localparam int unsigned KeptW = 5;
  // slack of the triangle test and lower range bound
  localparam int unsigned SlackMm = 1000;

  // configuration register indexes
  localparam logic CfgGateEnable = 1'b0;
  localparam logic CfgMaxRange = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic                     store;
    logic                     excl;
    logic [PosW-1:0]          pos;
    logic [PosW-1:0]          slot;
    logic [NumW-1:0]          num;
    logic                     last;
    logic                     gate;
    logic                     ovf;
    logic signed [CoordW-1:0] range;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
  } entry_t;

  // stored measurement
  typedef struct packed {
    logic signed [CoordW-1:0] range;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic [PosW-1:0]          idx;
  } meas_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
    logic push;
    logic pop;
  } queue_status_t;

  typedef enum logic [2:0] {
    BkPop,
    BkRead,
    BkDiff,
    BkMul,
    BkCmp,
    BkDecide
  } back_state_e;

endpackage

>>> sv/range_triangle_gate.sv
// ----------------------------------------------------------------------------
// range_triangle_gate
// plausibility gate for one set of ranging measurements
// ----------------------------------------------------------------------------
// Items are taken one a cycle while the two-entry queue is not full, and
// stored by the back end at one a cycle while it is idle, so a set streams
// in at about one item a cycle. The item flagged last starts the evaluation:
// with gating on and n >= 3 stored, each entry is tested against every other
// through one shared squaring multiplier (five squares a pair). While the
// evaluation runs the back end takes nothing, so the queue fills after two
// more items and the input stalls until it ends. One result per set is held
// in an output register while the next set is accepted; a closing item
// waits in the queue while that register is full and the output is stalled.
`include "range_triangle_gate_macros.svh"

module range_triangle_gate #(
  parameter int unsigned MAX_STORED = 16,
  parameter int unsigned MAX_INPUTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [rtg_pkg::MaxRangeW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              usable_i,
  input  logic signed [rtg_pkg::CoordW-1:0] range_mm_i,
  input  logic signed [rtg_pkg::CoordW-1:0] anchor_x_mm_i,
  input  logic signed [rtg_pkg::CoordW-1:0] anchor_y_mm_i,
  input  logic signed [rtg_pkg::CoordW-1:0] anchor_z_mm_i,
  input  logic                              last_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rtg_pkg::MaskW-1:0]         excluded_mask_o,
  output logic [rtg_pkg::MaskW-1:0]         kept_mask_o,
  output logic [rtg_pkg::KeptW-1:0]         kept_count_o,
  output logic                              overflow_o
);

  logic                          gate_q;
  logic [rtg_pkg::MaxRangeW-1:0] max_q;
  logic                          take, pop;
  rtg_pkg::entry_t               entry_in, entry_out;
  rtg_pkg::queue_status_t        qs;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= 1'b1;
      max_q  <= 23'd100000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtg_pkg::CfgGateEnable: gate_q <= cfg_data_i[0];
        rtg_pkg::CfgMaxRange:   max_q  <= cfg_data_i;
        default:                gate_q <= gate_q;
      endcase
    end
  end

  // input transaction
  assign in_stall_o = qs.full;
  assign take       = in_valid_i && !qs.full;

  rtg_front #(.MAX_STORED(MAX_STORED), .MAX_INPUTS(MAX_INPUTS)) u_front (
    .clk_i, .rst_ni,
    .take_i(take), .gate_enable_i(gate_q), .max_range_i(max_q),
    .usable_i, .range_i(range_mm_i), .ax_i(anchor_x_mm_i), .ay_i(anchor_y_mm_i),
    .az_i(anchor_z_mm_i), .last_i(last_item_i), .entry_o(entry_in)
  );

  rtg_queue u_queue (
    .clk_i, .rst_ni, .push_i(take), .data_i(entry_in), .pop_i(pop),
    .data_o(entry_out), .status_o(qs)
  );

  rtg_back #(.MAX_STORED(MAX_STORED)) u_back (
    .clk_i, .rst_ni, .entry_i(entry_out), .empty_i(qs.empty), .pop_o(pop),
    .out_stall_i, .out_valid_o, .excluded_mask_o, .kept_mask_o, .kept_count_o,
    .overflow_o
  );

  // checks
  `RTG_NEVER(a_pop_empty, qs.pop && qs.empty, "pop from empty queue")
  `RTG_ASSERT(a_masks_disjoint, out_valid_o |-> ((excluded_mask_o & kept_mask_o) == '0), "kept and excluded overlap")
  `RTG_ASSERT(a_kept_count, out_valid_o |-> (($countones(kept_mask_o) == kept_count_o) || (kept_count_o == 5'd31)), "kept count mismatch")

endmodule

>>> sv/rtg_front.sv
// ----------------------------------------------------------------------------
// rtg_front
// accepts measurements, applies the range bounds and assigns store slots
// ----------------------------------------------------------------------------
module rtg_front #(
  parameter int unsigned MAX_STORED = 16,
  parameter int unsigned MAX_INPUTS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic                             gate_enable_i,
  input  logic [rtg_pkg::MaxRangeW-1:0]    max_range_i,
  input  logic                             usable_i,
  input  logic signed [rtg_pkg::CoordW-1:0] range_i,
  input  logic signed [rtg_pkg::CoordW-1:0] ax_i,
  input  logic signed [rtg_pkg::CoordW-1:0] ay_i,
  input  logic signed [rtg_pkg::CoordW-1:0] az_i,
  input  logic                             last_i,
  output rtg_pkg::entry_t                  entry_o
);

  localparam int unsigned IW = $clog2(MAX_INPUTS + 1);
  localparam int unsigned CW = $clog2(MAX_STORED + 1);

  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  logic [rtg_pkg::NumW-1:0] idx_w, cnt_w;
  logic                     in_set, out_of_bounds;

  // classification of the item on the port
  always_comb begin
    idx_w = rtg_pkg::NumW'(idx_q);
    cnt_w = rtg_pkg::NumW'(cnt_q);
    in_set = (idx_w < rtg_pkg::NumW'(MAX_INPUTS));
    out_of_bounds = (range_i < -$signed(25'(rtg_pkg::SlackMm))) ||
                    ($signed({range_i[rtg_pkg::CoordW-1], range_i}) >
                     $signed({2'b00, max_range_i}));

    entry_o       = '0;
    entry_o.pos   = idx_w[rtg_pkg::PosW-1:0];
    entry_o.slot  = cnt_w[rtg_pkg::PosW-1:0];
    entry_o.last  = last_i;
    entry_o.gate  = gate_enable_i;
    entry_o.range = range_i;
    entry_o.ax    = ax_i;
    entry_o.ay    = ay_i;
    entry_o.az    = az_i;

    idx_d = idx_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (!in_set) begin
      ovf_d = 1'b1;
    end else begin
      idx_d = idx_q + 1'b1;
      if (usable_i && (cnt_w < rtg_pkg::NumW'(MAX_STORED))) begin
        if (gate_enable_i && out_of_bounds) begin
          entry_o.excl = 1'b1;
        end else begin
          entry_o.store = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
    entry_o.ovf = ovf_d;
    entry_o.num = rtg_pkg::NumW'(cnt_d);
  end

  // set counters, cleared after the closing item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        idx_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        idx_q <= idx_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

>>> sv/rtg_queue.sv
// ----------------------------------------------------------------------------
// rtg_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module rtg_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rtg_pkg::entry_t       data_i,
  input  logic                  pop_i,
  output rtg_pkg::entry_t       data_o,
  output rtg_pkg::queue_status_t status_o
);

  rtg_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign data_o          = mem_q[rd_q];
  assign status_o.full   = (fill_q == 2'd2);
  assign status_o.empty  = (fill_q == 2'd0);
  assign status_o.push   = push_i;
  assign status_o.pop    = pop_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

>>> sv/rtg_back.sv
// ----------------------------------------------------------------------------
// rtg_back
// stores measurements and runs the pairwise triangle test at set end
// ----------------------------------------------------------------------------
module rtg_back #(
  parameter int unsigned MAX_STORED = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtg_pkg::entry_t               entry_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [rtg_pkg::MaskW-1:0]     excluded_mask_o,
  output logic [rtg_pkg::MaskW-1:0]     kept_mask_o,
  output logic [rtg_pkg::KeptW-1:0]     kept_count_o,
  output logic                          overflow_o
);

  localparam int unsigned SW = $clog2(MAX_STORED);
  localparam int unsigned CW = $clog2(MAX_STORED + 1);
  localparam int unsigned OpW = 26;
  localparam int unsigned SqW = 51;

  rtg_pkg::back_state_e state_q, state_d;

  rtg_pkg::meas_t mem_q [MAX_STORED];
  rtg_pkg::meas_t rd_a_q, rd_b_q;

  logic [SW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] n_q, n_d, cnt_q, cnt_d, kept_q, kept_d, limit;
  logic [2:0]    k_q, k_d;
  logic          test_q, test_d;
  logic [rtg_pkg::MaskW-1:0] ex_q, ex_d, km_q, km_d;

  logic signed [OpW-1:0] dx_q, dy_q, dz_q, sum_q, dif_q, op;
  logic signed [2*OpW-1:0] prod;
  logic [SqW-1:0] d2_q, d2_d, ss_q, ss_d, sd_q, sd_d;
  logic [OpW-1:0] dx_d, dy_d, dz_d, sum_d, dif_d;

  logic out_valid_q, out_load;
  logic [rtg_pkg::MaskW-1:0] out_ex_q, out_km_q;
  logic [rtg_pkg::KeptW-1:0] out_kc_q;
  logic out_ovf_q, ovf_q, ovf_d;

  logic [CW-1:0] j_next, i_next;
  logic          conflict, out_free, store_wr;
  logic signed [OpW-1:0] ri, rj, rdf;

  assign out_free = !out_valid_q || !out_stall_i;
  assign j_next   = CW'(j_q) + 1'b1;
  assign i_next   = CW'(i_q) + 1'b1;
  assign limit    = (n_q < CW'(5)) ? CW'(1) : CW'((n_q - 1'b1) >> 1);

  // squaring unit shared by all five squares of a pair
  always_comb begin
    case (k_q)
      3'd0:    op = dx_q;
      3'd1:    op = dy_q;
      3'd2:    op = dz_q;
      3'd3:    op = sum_q;
      default: op = dif_q;
    endcase
    prod = op * op;
  end

  // pair difference terms
  always_comb begin
    ri    = OpW'(rd_a_q.range);
    rj    = OpW'(rd_b_q.range);
    rdf   = ri - rj;
    dx_d  = OpW'(rd_a_q.ax) - OpW'(rd_b_q.ax);
    dy_d  = OpW'(rd_a_q.ay) - OpW'(rd_b_q.ay);
    dz_d  = OpW'(rd_a_q.az) - OpW'(rd_b_q.az);
    sum_d = ri + rj + OpW'(rtg_pkg::SlackMm);
    dif_d = (rdf[OpW-1] ? -rdf : rdf) - OpW'(rtg_pkg::SlackMm);
  end

  assign conflict = sum_q[OpW-1] || (ss_q < d2_q) ||
                    (!dif_q[OpW-1] && (dif_q != '0) && (sd_q > d2_q));

  // sequencer
  always_comb begin
    state_d  = state_q;
    i_d = i_q; j_d = j_q; n_d = n_q; cnt_d = cnt_q; k_d = k_q;
    test_d = test_q; ex_d = ex_q; km_d = km_q; kept_d = kept_q; ovf_d = ovf_q;
    d2_d = d2_q; ss_d = ss_q; sd_d = sd_q;
    pop_o    = 1'b0;
    store_wr = 1'b0;
    out_load = 1'b0;
    case (state_q)
      rtg_pkg::BkPop: begin
        if (!empty_i && (!entry_i.last || out_free)) begin
          pop_o    = 1'b1;
          store_wr = entry_i.store;
          if (entry_i.excl) ex_d = ex_q | (rtg_pkg::MaskW'(1) << entry_i.pos);
          if (entry_i.last) begin
            n_d    = entry_i.num[CW-1:0];
            test_d = entry_i.gate && (entry_i.num >= rtg_pkg::NumW'(3));
            ovf_d  = entry_i.ovf;
            i_d = '0; j_d = '0; cnt_d = '0; km_d = '0; kept_d = '0;
            if (entry_i.num == '0) begin
              out_load = 1'b1;
            end else begin
              state_d = rtg_pkg::BkRead;
            end
          end
        end
      end
      rtg_pkg::BkRead: begin
        state_d = rtg_pkg::BkDiff;
      end
      rtg_pkg::BkDiff: begin
        k_d  = '0;
        d2_d = '0;
        if (!test_q) begin
          state_d = rtg_pkg::BkDecide;
        end else if (j_q == i_q) begin
          if (j_next == n_q) begin
            state_d = rtg_pkg::BkDecide;
          end else begin
            j_d = SW'(j_next);
            state_d = rtg_pkg::BkRead;
          end
        end else begin
          state_d = rtg_pkg::BkMul;
        end
      end
      rtg_pkg::BkMul: begin
        k_d = k_q + 3'd1;
        case (k_q)
          3'd3:    ss_d = prod[SqW-1:0];
          3'd4:    sd_d = prod[SqW-1:0];
          default: d2_d = d2_q + prod[SqW-1:0];
        endcase
        if (k_q == 3'd4) state_d = rtg_pkg::BkCmp;
      end
      rtg_pkg::BkCmp: begin
        if (conflict) cnt_d = cnt_q + 1'b1;
        if (j_next == n_q) begin
          state_d = rtg_pkg::BkDecide;
        end else begin
          j_d = SW'(j_next);
          state_d = rtg_pkg::BkRead;
        end
      end
      rtg_pkg::BkDecide: begin
        if (test_q && (cnt_q > limit)) begin
          ex_d = ex_q | (rtg_pkg::MaskW'(1) << rd_a_q.idx);
        end else begin
          km_d   = km_q | (rtg_pkg::MaskW'(1) << rd_a_q.idx);
          kept_d = kept_q + 1'b1;
        end
        cnt_d = '0;
        j_d   = '0;
        if (i_next == n_q) begin
          out_load = 1'b1;
          state_d  = rtg_pkg::BkPop;
        end else begin
          i_d     = SW'(i_next);
          state_d = rtg_pkg::BkRead;
        end
      end
      default: state_d = rtg_pkg::BkPop;
    endcase
  end

  // measurement store with two registered read ports
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      mem_q[entry_i.slot[SW-1:0]] <= '{range: entry_i.range, ax: entry_i.ax,
                                       ay: entry_i.ay, az: entry_i.az,
                                       idx: entry_i.pos};
    end
    rd_a_q <= mem_q[i_q];
    rd_b_q <= mem_q[j_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == rtg_pkg::BkDiff) begin
      dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d; sum_q <= sum_d; dif_q <= dif_d;
    end
    d2_q <= d2_d;
    ss_q <= ss_d;
    sd_q <= sd_d;
    k_q  <= k_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtg_pkg::BkPop;
      i_q <= '0; j_q <= '0; n_q <= '0; cnt_q <= '0; test_q <= 1'b0;
      ex_q <= '0; km_q <= '0; kept_q <= '0; ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; n_q <= n_d; cnt_q <= cnt_d; test_q <= test_d;
      km_q <= km_d; kept_q <= kept_d; ovf_q <= ovf_d;
      ex_q <= out_load ? '0 : ex_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ex_q  <= ex_d;
      out_km_q  <= km_d;
      out_kc_q  <= (rtg_pkg::NumW'(kept_d) > rtg_pkg::NumW'(31)) ? 5'd31
                                                                 : rtg_pkg::KeptW'(kept_d);
      out_ovf_q <= ovf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign excluded_mask_o = out_ex_q;
  assign kept_mask_o     = out_km_q;
  assign kept_count_o    = out_kc_q;
  assign overflow_o      = out_ovf_q;

endmodule
